// ----- hdl/dmf_pkg.sv -----
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared constants and types of the duplicate message filter.
// ----------------------------------------------------------------------------
package dmf_pkg;

    localparam int TABLE_ENTRIES  = 8;
    localparam int SERIAL_HISTORY = 5;

    localparam int SOURCE_W = 32;
    localparam int SERIAL_W = 8;
    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int PTR_W    = (SERIAL_HISTORY > 1) ? $clog2(SERIAL_HISTORY) : 1;

    localparam int IN_W     = SOURCE_W + SERIAL_W;
    localparam int IN_BYTES = (IN_W + 7) / 8;
    localparam int OUT_W    = 8;

    typedef struct packed {
        logic [PTR_W-1:0]                         slot_ptr;
        logic [SERIAL_HISTORY-1:0][SERIAL_W-1:0]  serials;
        logic [SOURCE_W-1:0]                      source;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_REP_RD,
        ST_REP_WR,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/dmf_ram.sv -----
// ----------------------------------------------------------------------------
// dmf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/duplicate_message_filter.sv -----
// ----------------------------------------------------------------------------
// duplicate_message_filter
// Flags messages whose source and serial were already seen in a small cache.
//
// channel | dir | beat contents (low bit first)           | handshake
// s_*     | in  | tdata: source_id[31:0], serial_number[7:0] | tvalid/tready
// m_*     | out | tdata: is_new[0], zero pad[7:1]           | tvalid/tready
//
// For each item, the table scan issues one row read per cycle from the entry
// RAM (registered read port), then the hit state checks the history and, for a
// new serial, writes the row back, or a miss reads and rewrites the replaced
// row. Reset clears per-entry valid bits; an invalid row reads as zero. A new
// item is taken while a result waits in the output register; the engine holds
// its next result until that register drains.
// ----------------------------------------------------------------------------
module duplicate_message_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dmf_pkg::IN_BYTES*8-1:0]    s_tdata,  // source_id, serial_number
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dmf_pkg::OUT_W-1:0]         m_tdata   // is_new, zero pad
);

    dmf_pkg::state_t state_reg, state_next;

    logic [dmf_pkg::SOURCE_W-1:0]      src_reg, src_next;
    logic [dmf_pkg::SERIAL_W-1:0]      ser_reg, ser_next;
    logic [dmf_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [dmf_pkg::IDX_W-1:0]         pidx_reg, pidx_next;
    logic [dmf_pkg::IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic [dmf_pkg::IDX_W-1:0]         rp_reg, rp_next;
    logic                              pend_reg, pend_next;
    logic                              issued_all_reg, issued_all_next;
    logic [dmf_pkg::TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                              rd_valid_reg;
    dmf_pkg::row_t                     row_reg, row_next;
    logic                              result_reg, result_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              out_new_reg, out_new_next;

    logic                              ram_we;
    logic [dmf_pkg::IDX_W-1:0]         ram_waddr;
    dmf_pkg::row_t                     ram_wrow;
    logic                              ram_re;
    logic [dmf_pkg::IDX_W-1:0]         ram_raddr;
    logic [dmf_pkg::ROW_W-1:0]         ram_rdata;
    dmf_pkg::row_t                     row_rd;

    dmf_ram #(
        .WIDTH (dmf_pkg::ROW_W),
        .DEPTH (dmf_pkg::TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wrow),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign row_rd   = rd_valid_reg ? dmf_pkg::row_t'(ram_rdata) : '0;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dmf_pkg::OUT_W-1){1'b0}}, out_new_reg};

    always_comb
    begin
        logic                         match;
        logic                         issue;
        logic                         dup;
        logic [dmf_pkg::PTR_W-1:0]    slot;
        logic                         out_free;
        dmf_pkg::row_t                wrow;

        state_next      = state_reg;
        src_next        = src_reg;
        ser_next        = ser_reg;
        idx_next        = idx_reg;
        pidx_next       = pidx_reg;
        hit_idx_next    = hit_idx_reg;
        rp_next         = rp_reg;
        pend_next       = 1'b0;
        issued_all_next = issued_all_reg;
        valid_next      = valid_reg;
        row_next        = row_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg;
        out_new_next    = out_new_reg;
        s_tready        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;
        match           = 1'b0;
        issue           = 1'b0;
        dup             = 1'b0;
        slot            = '0;
        wrow            = row_reg;
        out_free        = !out_valid_reg || m_tready;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            dmf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    src_next        = s_tdata[dmf_pkg::SOURCE_W-1:0];
                    ser_next        = s_tdata[dmf_pkg::IN_W-1:dmf_pkg::SOURCE_W];
                    idx_next        = '0;
                    issued_all_next = 1'b0;
                    state_next      = dmf_pkg::ST_SCAN;
                end
            end

            dmf_pkg::ST_SCAN:
            begin
                match = pend_reg && (row_rd.source == src_reg);
                issue = !issued_all_reg && !match;
                if (issue)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg;
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + 1'b1;
                    if (idx_reg == dmf_pkg::IDX_W'(dmf_pkg::TABLE_ENTRIES - 1))
                    begin
                        issued_all_next = 1'b1;
                    end
                end
                if (match)
                begin
                    row_next     = row_rd;
                    hit_idx_next = pidx_reg;
                    state_next   = dmf_pkg::ST_HIT;
                end
                else if (pend_reg &&
                         pidx_reg == dmf_pkg::IDX_W'(dmf_pkg::TABLE_ENTRIES - 1))
                begin
                    state_next = dmf_pkg::ST_REP_RD;
                end
            end

            dmf_pkg::ST_HIT:
            begin
                for (int k = 0; k < dmf_pkg::SERIAL_HISTORY; k++)
                begin
                    if (row_reg.serials[k] == ser_reg)
                    begin
                        dup = 1'b1;
                    end
                end
                if (dup)
                begin
                    result_next = 1'b0;
                end
                else
                begin
                    if (row_reg.slot_ptr ==
                        dmf_pkg::PTR_W'(dmf_pkg::SERIAL_HISTORY - 1))
                    begin
                        slot = '0;
                    end
                    else
                    begin
                        slot = row_reg.slot_ptr + 1'b1;
                    end
                    wrow.slot_ptr      = slot;
                    wrow.serials[slot] = ser_reg;
                    ram_we             = 1'b1;
                    ram_waddr          = hit_idx_reg;
                    valid_next[hit_idx_reg] = 1'b1;
                    result_next        = 1'b1;
                end
                state_next = dmf_pkg::ST_DONE;
            end

            dmf_pkg::ST_REP_RD:
            begin
                if (rp_reg == dmf_pkg::IDX_W'(dmf_pkg::TABLE_ENTRIES - 1))
                begin
                    rp_next = '0;
                end
                else
                begin
                    rp_next = rp_reg + 1'b1;
                end
                ram_re     = 1'b1;
                ram_raddr  = rp_next;
                state_next = dmf_pkg::ST_REP_WR;
            end

            dmf_pkg::ST_REP_WR:
            begin
                wrow            = row_rd;
                wrow.source     = src_reg;
                wrow.serials[0] = ser_reg;
                ram_we          = 1'b1;
                ram_waddr       = rp_reg;
                valid_next[rp_reg] = 1'b1;
                result_next     = 1'b1;
                state_next      = dmf_pkg::ST_DONE;
            end

            dmf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_new_next   = result_reg;
                    state_next     = dmf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dmf_pkg::ST_IDLE;
            end
        endcase

        ram_wrow = wrow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dmf_pkg::ST_IDLE;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            issued_all_reg <= 1'b0;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            rp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            issued_all_reg <= issued_all_next;
            valid_reg      <= valid_next;
            rp_reg         <= rp_next;
            out_valid_reg  <= out_valid_next;
            if (ram_re)
            begin
                rd_valid_reg <= valid_reg[ram_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        ser_reg     <= ser_next;
        pidx_reg    <= pidx_next;
        hit_idx_reg <= hit_idx_next;
        row_reg     <= row_next;
        result_reg  <= result_next;
        out_new_reg <= out_new_next;
    end

endmodule

// ----- verif/duplicate_message_filter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// duplicate_message_filter_tb
// Self-checking bench for the duplicate message filter. A cycle-free cache
// model predicts the is_new flag of every accepted message. Directed cases
// cover the cleared table, field extremes and stale history after an entry
// is replaced. Random traffic then mixes sequence streams, retransmissions
// and noise under random stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module duplicate_message_filter_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_CYCLES   = 24;
    localparam int REPORT_LIMIT   = 10;
    localparam int POOL_SIZE      = 12;

    logic                                clk;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [dmf_pkg::IN_BYTES*8-1:0]      s_tdata;    // source_id, serial_number
    logic                                m_tvalid;
    logic                                m_tready;
    logic [dmf_pkg::OUT_W-1:0]           m_tdata;    // is_new, zero pad

    logic [dmf_pkg::SOURCE_W-1:0]        cache_src [dmf_pkg::TABLE_ENTRIES];
    logic [dmf_pkg::SERIAL_W-1:0]
        cache_ser [dmf_pkg::TABLE_ENTRIES][dmf_pkg::SERIAL_HISTORY];
    int                                  cache_slot [dmf_pkg::TABLE_ENTRIES];
    int                                  evict_ptr;

    bit                                  expected_is_new [$];
    int                                  mismatch_count;
    int                                  idle_cycles;
    int                                  hold_cycles;
    bit                                  tx_idle_en;
    bit                                  rx_idle_en;

    duplicate_message_filter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit predict_is_new(input logic [dmf_pkg::SOURCE_W-1:0] src,
                                          input logic [dmf_pkg::SERIAL_W-1:0] ser);
        int hit_row;
        int slot;
        hit_row = -1;
        for (int e = 0; e < dmf_pkg::TABLE_ENTRIES; e++)
        begin
            if (hit_row < 0 && cache_src[e] == src)
                hit_row = e;
        end
        if (hit_row >= 0)
        begin
            for (int k = 0; k < dmf_pkg::SERIAL_HISTORY; k++)
            begin
                if (cache_ser[hit_row][k] == ser)
                    return 1'b0;
            end
            slot = (cache_slot[hit_row] + 1) % dmf_pkg::SERIAL_HISTORY;
            cache_slot[hit_row] = slot;
            cache_ser[hit_row][slot] = ser;
            return 1'b1;
        end
        evict_ptr = (evict_ptr + 1) % dmf_pkg::TABLE_ENTRIES;
        cache_src[evict_ptr] = src;
        cache_ser[evict_ptr][0] = ser;
        return 1'b1;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Keep tvalid high between back-to-back beats; lower it only for a gap.
    task automatic send_message(input logic [dmf_pkg::SOURCE_W-1:0] src,
                                input logic [dmf_pkg::SERIAL_W-1:0] ser);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ser, src};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_is_new.push_back(predict_is_new(src, ser));
    endtask

    task automatic test_cleared_table();
        send_message(32'h0000_0000, 8'h00);
        send_message(32'h0000_0000, 8'h00);
        send_message(32'h0000_0000, 8'h01);
        send_message(32'h0000_0000, 8'h01);
    endtask

    task automatic test_field_extremes();
        send_message(32'hFFFF_FFFF, 8'hFF);
        send_message(32'hFFFF_FFFF, 8'hFF);
        send_message(32'hFFFF_FFFF, 8'h00);
        send_message(32'hFFFF_FFFF, 8'h80);
        send_message(32'h8000_0000, 8'h7F);
    endtask

    // Fill one row, cycle the replace pointer back onto it, then hit a stale serial.
    task automatic test_stale_history();
        send_message(32'h1234_5678, 8'd11);
        send_message(32'h1234_5678, 8'd12);
        send_message(32'h1234_5678, 8'd13);
        for (int i = 0; i < dmf_pkg::TABLE_ENTRIES; i++)
            send_message(32'hA5A5_0000 + i, 8'd50);
        send_message(32'hA5A5_0000 + dmf_pkg::TABLE_ENTRIES - 1, 8'd12);
    endtask

    task automatic test_random_traffic(input int count);
        logic [dmf_pkg::SOURCE_W-1:0] pool [POOL_SIZE];
        logic [dmf_pkg::SERIAL_W-1:0] next_ser [POOL_SIZE];
        logic [dmf_pkg::SOURCE_W-1:0] src;
        logic [dmf_pkg::SERIAL_W-1:0] ser;
        int                           pick;
        int                           roll;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool[i]     = $urandom;
            next_ser[i] = 8'($urandom);
        end
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                pick           = $urandom_range(0, POOL_SIZE - 1);
                pool[pick]     = $urandom;
                next_ser[pick] = 8'($urandom);
            end
            pick = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6)
                                              : $urandom_range(0, POOL_SIZE - 1);
            src  = pool[pick];
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                ser = next_ser[pick];
                next_ser[pick] = next_ser[pick] + 8'd1;
            end
            else if (roll < 82)
                ser = next_ser[pick] - 8'($urandom_range(1, 7));
            else if (roll < 90)
                ser = 8'($urandom);
            else if (roll < 94)
            begin
                src = 32'h0000_0000;
                ser = 8'($urandom_range(0, 7));
            end
            else if (roll < 96)
            begin
                src = 32'hFFFF_FFFF;
                ser = 8'($urandom);
            end
            else
            begin
                src = $urandom;
                ser = 8'($urandom);
            end
            send_message(src, ser);
        end
    endtask

    // Hold the output long enough that the block fills and stalls its input.
    task automatic test_backpressure();
        hold_cycles = HOLD_OFF_LEN;
        test_random_traffic(20);
    endtask

    initial
    begin : main
        rst_n          = 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        mismatch_count = 0;
        hold_cycles    = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        evict_ptr      = 0;
        for (int e = 0; e < dmf_pkg::TABLE_ENTRIES; e++)
        begin
            cache_src[e]  = '0;
            cache_slot[e] = 0;
            for (int k = 0; k < dmf_pkg::SERIAL_HISTORY; k++)
                cache_ser[e][k] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_table();
        test_field_extremes();
        test_stale_history();
        test_random_traffic(300);
        test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_traffic(260);

        s_tvalid <= 1'b0;
        while (expected_is_new.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** duplicate_message_filter: PASSED **");
        else
            $display("** duplicate_message_filter: FAILED **");
        $finish;
    end

    initial
    begin : output_ready
        int n;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                n = hold_cycles;
                hold_cycles = 0;
                repeat (n) @(posedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_is_new.size() == 0)
                note_failure($sformatf("unexpected beat, actual %02h", m_tdata));
            else if (m_tdata !== {{(dmf_pkg::OUT_W-1){1'b0}}, expected_is_new[0]})
                note_failure($sformatf("is_new expected %0b, actual tdata %02h",
                                       expected_is_new.pop_front(), m_tdata));
            else
                void'(expected_is_new.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** duplicate_message_filter: FAILED **");
            $finish;
        end
    end

endmodule

// ----- duplicate_message_filter.f -----
hdl/dmf_pkg.sv
hdl/dmf_ram.sv
hdl/duplicate_message_filter.sv
verif/duplicate_message_filter_tb.sv
